FILE: hw/rtl/receiver_line_parser_with_port_mux_defines.svh
// assertion macros for the receiver line parser
`ifndef RECEIVER_LINE_PARSER_WITH_PORT_MUX_DEFINES_SVH
`define RECEIVER_LINE_PARSER_WITH_PORT_MUX_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define RLP_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rlp check failed");

// next-cycle implication, clocked on clk, off during rst
`define RLP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rlp check failed");

`endif

FILE: hw/rtl/rlp_pkg.sv
`timescale 1ns / 1ps
package rlp_pkg;

  localparam int LINE_MAX       = 50;
  localparam int RECEIVER_COUNT = 3;
  localparam int FIELD_MAX      = 16;

  localparam int LINE_AW    = $clog2(LINE_MAX);
  localparam int LINE_CW    = $clog2(LINE_MAX + 1);
  localparam int SLOT_DEPTH = RECEIVER_COUNT * FIELD_MAX;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int PORT_W     = 2;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] AMP_CHAR     = 8'h26;
  localparam int PREFIX_LEN   = 4;
  localparam int AMP_POS_MIN  = 8;
  localparam int ATT_TAIL     = 4;

  typedef enum logic [1:0] {
    MODE_RX,
    MODE_PORT,
    MODE_READ,
    MODE_CLEAR
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EVAL,
    ST_COPY_SER,
    ST_COPY_ATT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic ready;
    logic exec;
    logic scan;
    logic eval;
    logic copy_ser;
    logic copy_att;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic parse_start;
    logic sweep_last;
    logic parse_ok;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h52;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h43;
      default: c = 8'h3D;
    endcase
    return c;
  endfunction

  function automatic logic [SLOT_AW-1:0] slot_base(input logic [PORT_W-1:0] p);
    return SLOT_AW'(int'(p) * FIELD_MAX);
  endfunction

  function automatic logic [1:0] select_code(input logic [PORT_W-1:0] p);
    logic [1:0] s;
    unique case (p)
      2'd1:    s = 2'd2;
      2'd2:    s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/rlp_in_if.sv
`timescale 1ns / 1ps
interface rlp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [1:0] read_port;
  logic       read_field;
  logic [3:0] read_index;

  modport source (
    output valid, mode, data_byte, read_port, read_field, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, data_byte, read_port, read_field, read_index,
    output ready
  );
endinterface

FILE: hw/rtl/rlp_out_if.sv
`timescale 1ns / 1ps
interface rlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] port;
  logic [1:0] select_bits;
  logic       line_done;
  logic       accepted;
  logic       overflow_drop;
  logic       receiving;
  logic [7:0] read_char;

  modport source (
    output valid, port, select_bits, line_done, accepted, overflow_drop,
    output receiving, read_char,
    input  ready
  );
  modport sink (
    input  valid, port, select_bits, line_done, accepted, overflow_drop,
    input  receiving, read_char,
    output ready
  );
endinterface

FILE: hw/rtl/rlp_ram.sv
`timescale 1ns / 1ps
module rlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rlp_ctrl.sv
`timescale 1ns / 1ps
module rlp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  rlp_pkg::sts_t sts,
  output rlp_pkg::cmd_t cmd
);

  rlp_pkg::state_t state;
  rlp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      rlp_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.accept) begin
          state_next = rlp_pkg::ST_EXEC;
        end
      end
      rlp_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.parse_start ? rlp_pkg::ST_SCAN : rlp_pkg::ST_FINISH;
      end
      rlp_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.sweep_last) begin
          state_next = rlp_pkg::ST_EVAL;
        end
      end
      rlp_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.parse_ok ? rlp_pkg::ST_COPY_SER : rlp_pkg::ST_FINISH;
      end
      rlp_pkg::ST_COPY_SER: begin
        cmd.copy_ser = 1'b1;
        if (sts.sweep_last) begin
          state_next = rlp_pkg::ST_COPY_ATT;
        end
      end
      rlp_pkg::ST_COPY_ATT: begin
        cmd.copy_att = 1'b1;
        if (sts.sweep_last) begin
          state_next = rlp_pkg::ST_FINISH;
        end
      end
      rlp_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = rlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rlp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rlp_dp.sv
`timescale 1ns / 1ps
module rlp_dp (
  input  logic          clk,
  input  logic          rst,
  rlp_in_if.sink        req,
  rlp_out_if.source     rsp,
  input  rlp_pkg::cmd_t cmd,
  output rlp_pkg::sts_t sts
);

  localparam int CW = rlp_pkg::LINE_CW;
  localparam int AW = rlp_pkg::LINE_AW;
  localparam int SW = rlp_pkg::SLOT_AW;
  localparam int SD = rlp_pkg::SLOT_DEPTH;

  // captured word
  rlp_pkg::mode_t mode_r;
  logic [7:0]     byte_r;
  logic [1:0]     rport_r;
  logic           rfield_r;
  logic [3:0]     ridx_r;

  logic [CW-1:0]                  line_count;
  logic [rlp_pkg::PORT_W-1:0]     current_port;
  logic [SD-1:0]                  ser_valid;
  logic [SD-1:0]                  att_valid;

  logic done_r, acc_r, drop_r;

  // sweep unit shared by scan and copies
  logic [CW-1:0] sw_cnt, sw_limit, sw_off, sw_pcnt;
  logic          sw_plive;
  logic          sweep_start;
  logic [CW-1:0] start_limit, start_off;
  logic          sweep_run;
  logic          sweep_last;
  logic [CW:0]   line_sum;

  logic          prefix_ok;
  logic          amp_found;
  logic [CW-1:0] amp_pos;
  logic [CW-1:0] att_off, att_len;
  logic [CW-1:0] ser_raw, ser_len, att_raw, att_lim;

  logic          accept;
  logic          is_newline;
  logic          parse_start;
  logic          parse_ok;
  logic          out_free;

  logic          line_we;
  logic [7:0]    line_rdata;

  logic [SW-1:0] wr_addr;
  logic [SW-1:0] rd_addr;
  logic          ser_we, att_we;
  logic [7:0]    ser_rdata, att_rdata;
  logic [SD-1:0] port_mask;
  logic          rd_ok;
  logic          rd_valid;
  logic [7:0]    rd_char;

  assign req.ready = cmd.ready;
  assign accept    = req.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= rlp_pkg::mode_t'(req.mode);
      byte_r   <= req.data_byte;
      rport_r  <= req.read_port;
      rfield_r <= req.read_field;
      ridx_r   <= req.read_index;
    end
  end

  assign is_newline  = (mode_r == rlp_pkg::MODE_RX) && (byte_r == rlp_pkg::NEWLINE_CHAR);
  assign parse_start = is_newline && (int'(line_count) >= rlp_pkg::PREFIX_LEN);

  assign parse_ok = prefix_ok && amp_found
                    && (int'(amp_pos) >= rlp_pkg::AMP_POS_MIN)
                    && (int'(amp_pos) + rlp_pkg::ATT_TAIL <= int'(line_count));

  assign ser_raw = amp_pos - CW'(rlp_pkg::PREFIX_LEN);
  assign ser_len = (int'(ser_raw) > rlp_pkg::FIELD_MAX) ? CW'(rlp_pkg::FIELD_MAX) : ser_raw;
  assign att_raw = line_count - amp_pos - CW'(1);
  assign att_lim = (int'(att_raw) > rlp_pkg::FIELD_MAX) ? CW'(rlp_pkg::FIELD_MAX) : att_raw;

  // line count, port, flags
  assign line_we = cmd.exec && (mode_r == rlp_pkg::MODE_RX) && !is_newline
                   && (int'(line_count) < rlp_pkg::LINE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      current_port <= '0;
    end else begin
      if (cmd.exec && (mode_r == rlp_pkg::MODE_RX)) begin
        if (is_newline) begin
          if (!parse_start) begin
            line_count <= '0;
          end
        end else if (int'(line_count) >= rlp_pkg::LINE_MAX) begin
          line_count <= '0;
        end else begin
          line_count <= line_count + CW'(1);
        end
      end
      if (cmd.exec && (mode_r == rlp_pkg::MODE_PORT)) begin
        current_port <= (int'(current_port) >= rlp_pkg::RECEIVER_COUNT - 1)
                        ? '0 : current_port + rlp_pkg::PORT_W'(1);
      end
      if (cmd.eval) begin
        line_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_r <= 1'b0;
      acc_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (cmd.exec && (mode_r == rlp_pkg::MODE_RX)) begin
      done_r <= is_newline;
      drop_r <= !is_newline && (int'(line_count) >= rlp_pkg::LINE_MAX);
    end else if (cmd.eval) begin
      acc_r <= parse_ok;
    end
  end

  // sweep
  always_comb begin
    sweep_start = 1'b0;
    start_limit = line_count;
    start_off   = '0;
    priority if (cmd.exec && parse_start) begin
      sweep_start = 1'b1;
    end else if (cmd.eval && parse_ok) begin
      sweep_start = 1'b1;
      start_limit = ser_len;
      start_off   = CW'(rlp_pkg::PREFIX_LEN);
    end else if (cmd.copy_ser && sweep_last) begin
      sweep_start = 1'b1;
      start_limit = att_len;
      start_off   = att_off;
    end
  end

  assign sweep_run  = cmd.scan || cmd.copy_ser || cmd.copy_att;
  assign sweep_last = sw_plive && (sw_pcnt == sw_limit - CW'(1));
  assign line_sum   = {1'b0, sw_off} + {1'b0, sw_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_plive <= 1'b0;
    end else if (sweep_start) begin
      sw_cnt   <= '0;
      sw_limit <= start_limit;
      sw_off   <= start_off;
      sw_plive <= 1'b0;
    end else if (sweep_run) begin
      if (sw_cnt < sw_limit) begin
        sw_cnt   <= sw_cnt + CW'(1);
        sw_plive <= 1'b1;
        sw_pcnt  <= sw_cnt;
      end else begin
        sw_plive <= 1'b0;
      end
    end
  end

  // header check and first ampersand
  always_ff @(posedge clk) begin
    if (cmd.exec && parse_start) begin
      prefix_ok <= 1'b1;
      amp_found <= 1'b0;
    end else if (cmd.scan && sw_plive) begin
      if (int'(sw_pcnt) < rlp_pkg::PREFIX_LEN) begin
        if (line_rdata != rlp_pkg::prefix_char(sw_pcnt[1:0])) begin
          prefix_ok <= 1'b0;
        end
      end else if (!amp_found && (line_rdata == rlp_pkg::AMP_CHAR)) begin
        amp_found <= 1'b1;
        amp_pos   <= sw_pcnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      att_off <= amp_pos + CW'(1);
      att_len <= att_lim;
    end
  end

  rlp_ram #(
    .WIDTH (8),
    .DEPTH (rlp_pkg::LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_count[AW-1:0]),
    .wdata (byte_r),
    .raddr (line_sum[AW-1:0]),
    .rdata (line_rdata)
  );

  // slot stores
  assign wr_addr = rlp_pkg::slot_base(current_port) + SW'(sw_pcnt);
  assign rd_addr = rlp_pkg::slot_base(rport_r) + SW'(ridx_r);
  assign ser_we  = cmd.copy_ser && sw_plive;
  assign att_we  = cmd.copy_att && sw_plive;

  always_comb begin
    for (int j = 0; j < SD; j++) begin
      port_mask[j] = (j >= int'(rlp_pkg::slot_base(current_port)))
                     && (j < int'(rlp_pkg::slot_base(current_port)) + rlp_pkg::FIELD_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= '0;
      att_valid <= '0;
    end else begin
      if (cmd.exec && (mode_r == rlp_pkg::MODE_CLEAR)) begin
        ser_valid <= '0;
        att_valid <= '0;
      end
      if (cmd.eval && parse_ok) begin
        ser_valid <= ser_valid & ~port_mask;
        att_valid <= att_valid & ~port_mask;
      end
      if (ser_we) begin
        ser_valid[wr_addr] <= 1'b1;
      end
      if (att_we) begin
        att_valid[wr_addr] <= 1'b1;
      end
    end
  end

  rlp_ram #(
    .WIDTH (8),
    .DEPTH (SD)
  ) u_ser_ram (
    .clk   (clk),
    .we    (ser_we),
    .waddr (wr_addr),
    .wdata (line_rdata),
    .raddr (rd_addr),
    .rdata (ser_rdata)
  );

  rlp_ram #(
    .WIDTH (8),
    .DEPTH (SD)
  ) u_att_ram (
    .clk   (clk),
    .we    (att_we),
    .waddr (wr_addr),
    .wdata (line_rdata),
    .raddr (rd_addr),
    .rdata (att_rdata)
  );

  assign rd_ok    = (int'(rport_r) < rlp_pkg::RECEIVER_COUNT)
                    && (int'(ridx_r) < rlp_pkg::FIELD_MAX);
  assign rd_valid = rd_ok && (rfield_r ? att_valid[rd_addr] : ser_valid[rd_addr]);
  assign rd_char  = ((mode_r == rlp_pkg::MODE_READ) && rd_valid)
                    ? (rfield_r ? att_rdata : ser_rdata) : 8'h00;

  // result register
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.port          <= current_port;
      rsp.select_bits   <= rlp_pkg::select_code(current_port);
      rsp.line_done     <= done_r;
      rsp.accepted      <= acc_r;
      rsp.overflow_drop <= drop_r;
      rsp.receiving     <= (line_count != '0);
      rsp.read_char     <= rd_char;
    end
  end

  assign sts.accept      = accept;
  assign sts.parse_start = parse_start;
  assign sts.sweep_last  = sweep_last;
  assign sts.parse_ok    = parse_ok;
  assign sts.out_free    = out_free;

endmodule

FILE: hw/rtl/receiver_line_parser_with_port_mux.sv
// receiver line parser with a three-way port mux
// req carries one word per command: mode, data_byte, read_port, read_field,
// read_index; rsp returns one word per command with port, select_bits,
// line_done, accepted, overflow_drop, receiving and read_char.
// one command is in work at a time; req.ready is high only while idle.
// port advance, clear, read and plain received bytes pass from idle through
// the exec and finish states to rsp.valid. a newline on a line of n >= 4
// bytes scans the line buffer one byte per cycle, then, if the line is
// accepted, copies the serial and attenuation strings one byte per cycle;
// the line buffer has a single read port.
// reset empties the line buffer, selects port 0 and makes every slot read
// as zero at once; no clearing pass is needed.
// the result sits in an output register: the next command is taken while it
// waits, and a stalled rsp holds that command's result until taken.
`timescale 1ns / 1ps
module receiver_line_parser_with_port_mux (
  input logic       clk,
  input logic       rst,
  rlp_in_if.sink    req,
  rlp_out_if.source rsp
);

  rlp_pkg::cmd_t cmd;
  rlp_pkg::sts_t sts;

  rlp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rlp_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

FILE: hw/rtl/rlp_checker.sv
`timescale 1ns / 1ps
`include "receiver_line_parser_with_port_mux_defines.svh"
module rlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] port,
  input logic [1:0] select_bits,
  input logic       line_done,
  input logic       accepted,
  input logic       overflow_drop,
  input logic       receiving,
  input logic [7:0] read_char
);

  // a stalled result word holds
  `RLP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_char) && $stable(port) && $stable(accepted))

  // one command in work at a time
  `RLP_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

  // mux select follows the port
  `RLP_ASSERT_NOW(a_select_map, rsp_valid, (port == 2'd0 && select_bits == 2'd0) || (port == 2'd1 && select_bits == 2'd2) || (port == 2'd2 && select_bits == 2'd1))

  // only a parsed line can be accepted
  `RLP_ASSERT_NOW(a_accept_needs_line, rsp_valid && accepted, line_done && !overflow_drop)

  // a newline or a drop leaves the buffer empty
  `RLP_ASSERT_NOW(a_empty_after_end, rsp_valid && (line_done || overflow_drop), !receiving)

endmodule

bind receiver_line_parser_with_port_mux rlp_checker u_rlp_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .port          (rsp.port),
  .select_bits   (rsp.select_bits),
  .line_done     (rsp.line_done),
  .accepted      (rsp.accepted),
  .overflow_drop (rsp.overflow_drop),
  .receiving     (rsp.receiving),
  .read_char     (rsp.read_char)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import rlp_pkg::*;

  localparam string REC_PREFIX = "REC=";
  localparam logic [1:0] SEL_PORT0 = 2'd0;
  localparam logic [1:0] SEL_PORT1 = 2'd2;
  localparam logic [1:0] SEL_PORT2 = 2'd1;
  localparam int RANDOM_WORDS = 1550;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    mode_t      mode;
    logic [7:0] data_byte;
    logic [1:0] read_port;
    logic       read_field;
    logic [3:0] read_index;
  } rx_cmd_t;

  typedef struct packed {
    logic [1:0] port;
    logic [1:0] select_bits;
    logic       line_done;
    logic       accepted;
    logic       overflow_drop;
    logic       receiving;
    logic [7:0] read_char;
  } reply_t;

  class rx_scoreboard;
    logic [7:0] line_buf [LINE_MAX];
    int         line_len;
    logic [1:0] cur_port;
    logic [7:0] serial_str [RECEIVER_COUNT][FIELD_MAX];
    logic [7:0] atten_str [RECEIVER_COUNT][FIELD_MAX];
    reply_t     pending [$];
    int         errors;

    function new();
      line_len = 0;
      cur_port = 2'd0;
      errors   = 0;
      foreach (line_buf[i]) line_buf[i] = 8'h00;
      clear_slots();
    endfunction

    function void clear_slots();
      foreach (serial_str[p, k]) begin
        serial_str[p][k] = 8'h00;
        atten_str[p][k]  = 8'h00;
      end
    endfunction

    function bit parse_line();
      int n;
      int amp;
      int ser_len;
      int att_len;
      n   = line_len;
      amp = -1;
      if (n < PREFIX_LEN) return 1'b0;
      for (int i = 0; i < PREFIX_LEN; i++)
        if (line_buf[i] != REC_PREFIX[i]) return 1'b0;
      for (int i = PREFIX_LEN; i < n; i++)
        if (amp < 0 && line_buf[i] == AMP_CHAR) amp = i;
      if (amp < 0) return 1'b0;
      if (amp - PREFIX_LEN <= 3) return 1'b0;
      if (n - amp - 1 <= 2) return 1'b0;
      ser_len = (amp - PREFIX_LEN > FIELD_MAX) ? FIELD_MAX : amp - PREFIX_LEN;
      att_len = (n - amp - 1 > FIELD_MAX) ? FIELD_MAX : n - amp - 1;
      for (int k = 0; k < FIELD_MAX; k++) begin
        serial_str[cur_port][k] = (k < ser_len) ? line_buf[PREFIX_LEN + k] : 8'h00;
        atten_str[cur_port][k]  = (k < att_len) ? line_buf[amp + 1 + k] : 8'h00;
      end
      return 1'b1;
    endfunction

    function void note_word(rx_cmd_t c);
      reply_t r;
      r = '0;
      case (c.mode)
        MODE_RX: begin
          if (c.data_byte == NEWLINE_CHAR) begin
            r.line_done = 1'b1;
            r.accepted  = parse_line();
            line_len    = 0;
          end else if (line_len >= LINE_MAX) begin
            r.overflow_drop = 1'b1;
            line_len        = 0;
          end else begin
            line_buf[line_len] = c.data_byte;
            line_len++;
          end
        end
        MODE_PORT: cur_port = (cur_port >= 2'd2) ? 2'd0 : cur_port + 2'd1;
        MODE_READ: begin
          if (int'(c.read_port) < RECEIVER_COUNT && int'(c.read_index) < FIELD_MAX)
            r.read_char = c.read_field ? atten_str[c.read_port][c.read_index]
                                       : serial_str[c.read_port][c.read_index];
        end
        default: clear_slots();
      endcase
      r.port        = cur_port;
      r.select_bits = (cur_port == 2'd1) ? SEL_PORT1 :
                      (cur_port == 2'd2) ? SEL_PORT2 : SEL_PORT0;
      r.receiving   = (line_len != 0);
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: port=%0d sel=%0d done=%0b acc=%0b drop=%0b rx=%0b chr=%02h",
                   got.port, got.select_bits, got.line_done, got.accepted,
                   got.overflow_drop, got.receiving, got.read_char);
        return;
      end
      want = pending.pop_front();
      if (got.port !== want.port || got.select_bits !== want.select_bits ||
          got.line_done !== want.line_done || got.accepted !== want.accepted ||
          got.overflow_drop !== want.overflow_drop || got.receiving !== want.receiving ||
          got.read_char !== want.read_char) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp: port=%0d sel=%0d done=%0b acc=%0b drop=%0b rx=%0b chr=%02h",
                   want.port, want.select_bits, want.line_done, want.accepted,
                   want.overflow_drop, want.receiving, want.read_char);
          $display("         got: port=%0d sel=%0d done=%0b acc=%0b drop=%0b rx=%0b chr=%02h",
                   got.port, got.select_bits, got.line_done, got.accepted,
                   got.overflow_drop, got.receiving, got.read_char);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rlp_in_if  req ();
  rlp_out_if rsp ();

  receiver_line_parser_with_port_mux u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rx_scoreboard sb;
  rx_cmd_t      cmd_q [$];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic rx_cmd_t make_cmd(mode_t m, logic [7:0] b);
    rx_cmd_t c;
    c.mode       = m;
    c.data_byte  = b;
    c.read_port  = 2'($urandom_range(0, 3));
    c.read_field = 1'($urandom_range(0, 1));
    c.read_index = 4'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    cmd_q.push_back(make_cmd(MODE_RX, b));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_line(string s);
    add_text(s);
    add_byte(NEWLINE_CHAR);
  endfunction

  function automatic void add_mode(mode_t m);
    cmd_q.push_back(make_cmd(m, 8'($urandom_range(0, 255))));
  endfunction

  function automatic void add_read(int p, int f, int idx);
    rx_cmd_t c;
    c            = make_cmd(MODE_READ, 8'($urandom_range(0, 255)));
    c.read_port  = 2'(p);
    c.read_field = 1'(f);
    c.read_index = 4'(idx);
    cmd_q.push_back(c);
  endfunction

  // any byte but newline, and no ampersand where a serial string goes
  function automatic logic [7:0] field_char(bit allow_amp);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == NEWLINE_CHAR || (!allow_amp && b == AMP_CHAR));
    return b;
  endfunction

  function automatic void build_directed();
    add_read(0, 0, 0);
    add_read(2, 1, 15);
    add_read(3, 0, 0);
    add_line("");
    add_line("REC");
    add_line("REC=ABCD&X&Z");
    add_read(0, 0, 0);
    add_read(0, 0, 3);
    add_read(0, 0, 4);
    add_read(0, 1, 2);
    add_read(0, 1, 3);
    add_line("REC=ABC&XYZ");
    add_line("REC=ABCD&XY");
    add_line("REC=ABCDEFGH");
    add_line("REX=ABCD&XYZ");
    add_mode(MODE_PORT);
    add_line("REC=ABCDEFGHIJKLMNOPQRST&abcdefghijklmnopqrst");
    add_read(1, 0, 15);
    add_read(1, 1, 15);
    add_read(3, 1, 15);
    add_mode(MODE_PORT);
    add_mode(MODE_PORT);
    add_text("REC=WXYZ");
    add_mode(MODE_CLEAR);
    add_line("&123");
    add_read(1, 0, 0);
    add_read(0, 0, 0);
    // full buffer of exactly LINE_MAX bytes, then a newline
    add_text(REC_PREFIX);
    for (int i = 0; i < FIELD_MAX; i++) add_byte(i[0] ? 8'hFF : 8'h00);
    add_byte(AMP_CHAR);
    for (int i = 0; i < LINE_MAX - FIELD_MAX - 5; i++) add_byte(i[0] ? 8'h00 : 8'hFF);
    add_byte(NEWLINE_CHAR);
    add_read(0, 0, 15);
    add_read(0, 1, 15);
    // one byte past a full buffer
    for (int i = 0; i <= LINE_MAX; i++) add_byte(8'h41 + 8'(i % 26));
    add_byte(NEWLINE_CHAR);
  endfunction

  function automatic void add_random_line();
    int  ser_len;
    int  att_len;
    int  flaw;
    bit  no_amp;
    ser_len = ($urandom_range(0, 4) != 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
    att_len = ($urandom_range(0, 4) != 0) ? $urandom_range(3, 30) : $urandom_range(0, 2);
    flaw    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 4) : -1;
    no_amp  = (flaw == 4);
    for (int i = 0; i < PREFIX_LEN; i++)
      add_byte((flaw == i) ? field_char(1'b1) : REC_PREFIX[i]);
    for (int i = 0; i < ser_len; i++) add_byte(field_char(1'b0));
    if (!no_amp) add_byte(AMP_CHAR);
    for (int i = 0; i < att_len; i++) add_byte(field_char(!no_amp));
    add_byte(NEWLINE_CHAR);
    if ($urandom_range(0, 1) == 1)
      for (int i = $urandom_range(1, 4); i > 0; i--)
        add_read($urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 15));
  endfunction

  function automatic void build_random(int target);
    int pick;
    while (cmd_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_random_line();
      end else if (pick < 70) begin
        for (int i = $urandom_range(1, 4); i > 0; i--)
          add_read($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 15));
      end else if (pick < 80) begin
        add_mode(MODE_PORT);
      end else if (pick < 83) begin
        add_mode(MODE_CLEAR);
      end else if (pick < 93) begin
        for (int i = $urandom_range(1, 8); i > 0; i--) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0) add_byte(NEWLINE_CHAR);
      end else begin
        for (int i = $urandom_range(LINE_MAX - 2, LINE_MAX + 6); i > 0; i--)
          add_byte(field_char(1'b1));
        if ($urandom_range(0, 1) == 1) add_byte(NEWLINE_CHAR);
      end
    end
  endfunction

  task automatic drive_words();
    int next;
    int burst;
    int gap;
    next = 0;
    while (next < cmd_q.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      gap   = $urandom_range(0, 5);
      for (int k = 0; k < burst && next < cmd_q.size(); k++) begin
        @(negedge clk);
        req.valid      <= 1'b1;
        req.mode       <= cmd_q[next].mode;
        req.data_byte  <= cmd_q[next].data_byte;
        req.read_port  <= cmd_q[next].read_port;
        req.read_field <= cmd_q[next].read_field;
        req.read_index <= cmd_q[next].read_index;
        do @(posedge clk); while (req.ready !== 1'b1);
        sb.note_word(cmd_q[next]);
        next++;
      end
      if (gap > 0) begin
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int kind;
    int span;
    int tick;
    rsp.ready = 1'b0;
    tick      = 0;
    forever begin
      kind = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (kind)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 99) < 70);
          2: rsp.ready <= (tick % 4 != 3);
          default: if ($urandom_range(0, 9) == 0) rsp.ready <= !rsp.ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    reply_t got;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got.port          = rsp.port;
      got.select_bits   = rsp.select_bits;
      got.line_done     = rsp.line_done;
      got.accepted      = rsp.accepted;
      got.overflow_drop = rsp.overflow_drop;
      got.receiving     = rsp.receiving;
      got.read_char     = rsp.read_char;
      sb.check_reply(got);
    end
  end

  initial begin
    sb             = new();
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.mode       = MODE_RX;
    req.data_byte  = 8'h00;
    req.read_port  = 2'd0;
    req.read_field = 1'b0;
    req.read_index = 4'd0;
    build_directed();
    build_random(RANDOM_WORDS);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drive_words();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rlp_pkg.sv
hw/rtl/rlp_in_if.sv
hw/rtl/rlp_out_if.sv
hw/rtl/rlp_ram.sv
hw/rtl/rlp_ctrl.sv
hw/rtl/rlp_dp.sv
hw/rtl/receiver_line_parser_with_port_mux.sv
hw/rtl/rlp_checker.sv
tb/sv/tb.sv
